/* sv/mqsc_pkg.sv */
package mqsc_pkg;

	localparam int TILE_W = 16;
	localparam int TIME_W = 48;
	localparam int CNT_W  = 32;
	localparam int RATE_W = 32;
	localparam int DLY_W  = 32;
	localparam int ADDR_W = 4;

	localparam logic [TILE_W-1:0] MIN_THR       = TILE_W'(32);
	localparam logic [RATE_W-1:0] RATE_LOW      = RATE_W'(1000000);
	localparam logic [RATE_W-1:0] RATE_MID      = RATE_W'(2000000);
	localparam logic [DLY_W-1:0]  DEFAULT_DELAY = DLY_W'(1200);
	localparam logic [3:0]        STREAK_MAX    = 4'd15;
	localparam logic [3:0]        DEFAULT_ENTRY = 4'd2;
	localparam logic [1:0]        STEP_COARSE   = 2'd3;
	localparam logic [1:0]        STEP_MID      = 2'd2;
	localparam logic [1:0]        STEP_MIN      = 2'd1;
	localparam logic [1:0]        STEP_FULL     = 2'd0;

	typedef enum logic [1:0] {
		REG_ENABLE,
		REG_BASE_STEP,
		REG_EXIT_DELAY,
		REG_ENTRY_FRAMES
	} reg_idx_t;

	typedef struct packed {
		logic [TILE_W-1:0] changed_tiles;
		logic [TILE_W-1:0] total_tiles;
		logic [RATE_W-1:0] target_rate;
		logic [TIME_W-1:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       quant_step;
		logic             step_changed;
		logic             large_motion;
		logic             restore_full;
		logic [CNT_W-1:0] motion_frames;
		logic [CNT_W-1:0] switches;
	} out_item_t;

	typedef struct packed {
		logic             enable;
		logic [1:0]       base_step;
		logic [DLY_W-1:0] exit_delay;
		logic [3:0]       entry_frames;
	} cfg_t;

	typedef struct packed {
		logic              mode_active;
		logic [3:0]        large_streak;
		logic [TIME_W-1:0] last_large_time;
		logic [TIME_W-1:0] entered_time;
		logic [1:0]        applied_step;
		logic [CNT_W-1:0]  motion_count;
		logic [CNT_W-1:0]  switch_count;
	} state_t;

endpackage

/* sv/mqsc_decide.sv */
module mqsc_decide
	import mqsc_pkg::*;
(
	input  cfg_t      cfg,
	input  state_t    cur,
	input  in_item_t  item,
	output state_t    nxt,
	output out_item_t res
);

	logic [TILE_W-1:0] thr;
	logic              big;
	logic              overwhelming;
	logic [1:0]        desired;
	logic [3:0]        streak_inc;
	logic              enter;
	logic [TIME_W-1:0] delay_ext;
	logic              quiet_ok;
	logic              active_ok;
	logic [1:0]        qstep;
	logic              chg;
	logic              restore;

	assign delay_ext = {{(TIME_W-DLY_W){1'b0}}, cfg.exit_delay};

	always_comb begin
		thr = item.total_tiles >> 3;
		if (thr < MIN_THR) begin
			thr = MIN_THR;
		end
		big          = item.changed_tiles >= thr;
		overwhelming = (item.total_tiles != '0) &&
			(item.changed_tiles >= (item.total_tiles >> 1));

		desired = cfg.base_step;
		if (item.target_rate < RATE_LOW && desired < STEP_COARSE) begin
			desired = STEP_COARSE;
		end else if (item.target_rate < RATE_MID && desired < STEP_MID) begin
			desired = STEP_MID;
		end

		streak_inc = (cur.large_streak < STREAK_MAX) ? cur.large_streak + 4'd1
			: cur.large_streak;

		// time running backwards keeps the mode on
		quiet_ok  = (item.now_ms >= cur.last_large_time) &&
			((item.now_ms - cur.last_large_time) >= delay_ext);
		active_ok = (item.now_ms >= cur.entered_time) &&
			((item.now_ms - cur.entered_time) >= delay_ext);
	end

	always_comb begin
		nxt     = cur;
		qstep   = STEP_FULL;
		chg     = 1'b0;
		restore = 1'b0;
		enter   = 1'b1;
		if (big) begin
			nxt.last_large_time = item.now_ms;
			nxt.motion_count    = cur.motion_count + CNT_W'(1);
			if (!cur.mode_active) begin
				nxt.large_streak = streak_inc;
				if (!overwhelming && streak_inc < cfg.entry_frames) begin
					enter = 1'b0;
				end else begin
					nxt.mode_active  = 1'b1;
					nxt.entered_time = item.now_ms;
				end
			end
			if (enter) begin
				if (cur.applied_step != desired) begin
					nxt.applied_step = desired;
					nxt.switch_count = cur.switch_count + CNT_W'(1);
					chg              = 1'b1;
				end
				qstep = desired;
			end
		end else begin
			nxt.large_streak = '0;
			if (cur.mode_active && quiet_ok && active_ok) begin
				nxt.mode_active  = 1'b0;
				nxt.applied_step = STEP_FULL;
				nxt.switch_count = cur.switch_count + CNT_W'(1);
				chg              = 1'b1;
				restore          = 1'b1;
			end else begin
				qstep = cur.applied_step;
			end
		end

		res.quant_step    = qstep;
		res.step_changed  = chg;
		res.large_motion  = big;
		res.restore_full  = restore;
		res.motion_frames = nxt.motion_count;
		res.switches      = nxt.switch_count;

		// disabled: zero result, state held
		if (!cfg.enable) begin
			nxt = cur;
			res = '0;
		end
	end

endmodule

/* sv/motion_quality_step_controller.sv */
// motion quality step controller
// pipeline: an accepted item is held in the input register, then its result in the result register
// throughput: one item per cycle unless a full result register is stalled; the step decision
// is one pass of compare logic on the state registers between the input and result registers
// reset: arst_n clears state, counters and valid flags, and loads the register defaults
module motion_quality_step_controller
	import mqsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_item_t          in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output out_item_t         out_item,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t      cfg_q;
	state_t    state_q;
	state_t    state_nxt;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_s2;
	out_item_t res_nxt;
	logic      valid_s2;
	logic      advance;
	logic      cfg_wr;
	reg_idx_t  wr_idx;
	reg_idx_t  rd_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign wr_idx = reg_idx_t'(paddr[3:2]);
	assign rd_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable       <= 1'b1;
			cfg_q.base_step    <= STEP_MIN;
			cfg_q.exit_delay   <= DEFAULT_DELAY;
			cfg_q.entry_frames <= DEFAULT_ENTRY;
		end else if (cfg_wr) begin
			case (wr_idx)
				REG_ENABLE: begin
					cfg_q.enable <= pwdata[0];
				end
				REG_BASE_STEP: begin
					cfg_q.base_step <= (pwdata[1:0] == STEP_FULL) ? STEP_MIN : pwdata[1:0];
				end
				REG_EXIT_DELAY: begin
					cfg_q.exit_delay <= (pwdata == '0) ? DEFAULT_DELAY : pwdata;
				end
				REG_ENTRY_FRAMES: begin
					cfg_q.entry_frames <= pwdata[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (rd_idx)
			REG_ENABLE:       prdata = {31'b0, cfg_q.enable};
			REG_BASE_STEP:    prdata = {30'b0, cfg_q.base_step};
			REG_EXIT_DELAY:   prdata = cfg_q.exit_delay;
			REG_ENTRY_FRAMES: prdata = {28'b0, cfg_q.entry_frames};
			default:          prdata = '0;
		endcase
	end

	// a beat moves from s1 to the result register when that register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	mqsc_decide u_decide (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = res_s2;

`ifndef SYNTHESIS
	a_step_zero_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.mode_active |-> state_q.applied_step == STEP_FULL)
		else $error("applied step nonzero outside coarse mode");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s2 && out_stall && valid_s1)
		else $error("input stalled while result register can drain");

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("beat lost between s1 and result register");

	a_restore_clears_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_nxt.restore_full |=> !state_q.mode_active &&
			out_item.step_changed && out_item.quant_step == STEP_FULL)
		else $error("restore without leaving coarse mode");
`endif

endmodule

/* test/mqsc_tb_pkg.sv */
`timescale 1ns / 1ps

package mqsc_tb_pkg;
	import mqsc_pkg::*;

	class step_scoreboard;
		logic              enable;
		logic [1:0]        base_step;
		logic [DLY_W-1:0]  exit_delay;
		logic [3:0]        entry_frames;

		logic              mode_active;
		logic [3:0]        large_streak;
		logic [TIME_W-1:0] last_large_ms;
		logic [TIME_W-1:0] entered_ms;
		logic [1:0]        applied_step;
		logic [CNT_W-1:0]  motion_count;
		logic [CNT_W-1:0]  switch_count;

		out_item_t         expected_steps[$];
		int                errors;
		int                frames;
		int                checked;
		int                restores;

		function new();
			enable        = 1'b1;
			base_step     = STEP_MIN;
			exit_delay    = DEFAULT_DELAY;
			entry_frames  = DEFAULT_ENTRY;
			mode_active   = 1'b0;
			large_streak  = '0;
			last_large_ms = '0;
			entered_ms    = '0;
			applied_step  = STEP_FULL;
			motion_count  = '0;
			switch_count  = '0;
			errors        = 0;
			frames        = 0;
			checked       = 0;
			restores      = 0;
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 40) begin
				$display("[%0t] mismatch: %s", $time, msg);
			end
		endfunction

		function void configure(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_ENABLE: begin
					enable = value[0];
				end
				REG_BASE_STEP: begin
					base_step = (value[1:0] == STEP_FULL) ? STEP_MIN : value[1:0];
				end
				REG_EXIT_DELAY: begin
					exit_delay = (value == '0) ? DEFAULT_DELAY : value;
				end
				REG_ENTRY_FRAMES: begin
					entry_frames = value[3:0];
				end
				default: begin
				end
			endcase
		endfunction

		function out_item_t predict_step(in_item_t f);
			out_item_t         r;
			logic [TILE_W-1:0] thr;
			logic              big;
			logic              over;
			logic              enter;
			logic [1:0]        desired;
			r = '0;
			if (!enable) begin
				return r;
			end
			thr = f.total_tiles >> 3;
			if (thr < MIN_THR) begin
				thr = MIN_THR;
			end
			big  = f.changed_tiles >= thr;
			over = (f.total_tiles != '0) && (f.changed_tiles >= (f.total_tiles >> 1));
			r.large_motion = big;
			if (big) begin
				desired = base_step;
				enter   = 1'b1;
				if (f.target_rate < RATE_LOW && desired < STEP_COARSE) begin
					desired = STEP_COARSE;
				end else if (f.target_rate < RATE_MID && desired < STEP_MID) begin
					desired = STEP_MID;
				end
				last_large_ms = f.now_ms;
				motion_count  = motion_count + 1'b1;
				if (!mode_active) begin
					if (large_streak < STREAK_MAX) begin
						large_streak = large_streak + 1'b1;
					end
					// streak not long enough yet: frame is large but step stays at full quality
					if (!over && large_streak < entry_frames) begin
						enter = 1'b0;
					end else begin
						mode_active = 1'b1;
						entered_ms  = f.now_ms;
					end
				end
				if (enter) begin
					if (applied_step != desired) begin
						applied_step   = desired;
						switch_count   = switch_count + 1'b1;
						r.step_changed = 1'b1;
					end
					r.quant_step = desired;
				end
			end else begin
				large_streak = '0;
				// no modular difference: time running backwards keeps the mode
				if (mode_active && f.now_ms >= last_large_ms &&
						f.now_ms - last_large_ms >= exit_delay &&
						f.now_ms >= entered_ms &&
						f.now_ms - entered_ms >= exit_delay) begin
					mode_active    = 1'b0;
					applied_step   = STEP_FULL;
					switch_count   = switch_count + 1'b1;
					r.step_changed = 1'b1;
					r.restore_full = 1'b1;
				end else begin
					r.quant_step = applied_step;
				end
			end
			r.motion_frames = motion_count;
			r.switches      = switch_count;
			return r;
		endfunction

		function void note_frame(in_item_t f);
			expected_steps.push_back(predict_step(f));
			frames++;
		endfunction

		function void check_step(out_item_t got);
			out_item_t want;
			if (expected_steps.size() == 0) begin
				report("result beat with no frame pending");
				return;
			end
			want = expected_steps.pop_front();
			checked++;
			if (want.restore_full) begin
				restores++;
			end
			if (got.quant_step !== want.quant_step) begin
				report($sformatf("quant_step %0d, want %0d", got.quant_step, want.quant_step));
			end
			if (got.step_changed !== want.step_changed) begin
				report($sformatf("step_changed %0b, want %0b",
					got.step_changed, want.step_changed));
			end
			if (got.large_motion !== want.large_motion) begin
				report($sformatf("large_motion %0b, want %0b",
					got.large_motion, want.large_motion));
			end
			if (got.restore_full !== want.restore_full) begin
				report($sformatf("restore_full %0b, want %0b",
					got.restore_full, want.restore_full));
			end
			if (got.motion_frames !== want.motion_frames) begin
				report($sformatf("motion_frames %0d, want %0d",
					got.motion_frames, want.motion_frames));
			end
			if (got.switches !== want.switches) begin
				report($sformatf("switches %0d, want %0d", got.switches, want.switches));
			end
		endfunction

		function int pending();
			return expected_steps.size();
		endfunction
	endclass

endpackage

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
	import mqsc_pkg::*;
	import mqsc_tb_pkg::*;

	localparam int HOLD_CYCLES = 150;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	in_item_t          in_item   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_item_t         out_item;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [31:0]       pwdata    = '0;
	logic [31:0]       prdata;
	logic              pready;

	int                tx_idle_pct = 0;
	int                rx_idle_pct = 0;
	int                large_pct   = 70;
	int                over_pct    = 25;
	int                cfg_writes  = 0;
	bit                hold_rx     = 1'b0;
	logic [TIME_W-1:0] sim_ms      = '0;
	logic [DLY_W-1:0]  cur_delay   = DEFAULT_DELAY;
	step_scoreboard    sb;

	motion_quality_step_controller u_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result check first so an empty queue is caught before this edge's frame is noted
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_step(out_item);
		end
		if (arst_n && in_valid && !in_stall) begin
			sb.note_frame(in_item);
		end
	end

	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_rx = 1'b0;
			end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_frame(input in_item_t f);
		in_valid <= 1'b1;
		in_item  <= f;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic maybe_gap();
		if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.configure(idx, value);
		cfg_writes++;
		@(posedge clk);
	endtask

	task automatic set_config(input logic en, input logic [1:0] base, input logic [31:0] dly,
			input logic [3:0] entry);
		logic [31:0] junk;
		junk = $urandom;
		// unused upper bits carry noise
		write_reg(REG_ENABLE, {junk[31:1], en});
		write_reg(REG_BASE_STEP, {junk[31:2], base});
		write_reg(REG_EXIT_DELAY, dly);
		write_reg(REG_ENTRY_FRAMES, {junk[31:4], entry});
		cur_delay = (dly == '0) ? DEFAULT_DELAY : dly;
	endtask

	task automatic directed_frame(input logic [TILE_W-1:0] chg, input logic [TILE_W-1:0] tot,
			input logic [RATE_W-1:0] rate, input logic [TIME_W-1:0] ms);
		in_item_t f;
		f.changed_tiles = chg;
		f.total_tiles   = tot;
		f.target_rate   = rate;
		f.now_ms        = ms;
		send_frame(f);
	endtask

	function automatic in_item_t make_frame(input bit busy);
		in_item_t          f;
		logic [TILE_W-1:0] thr;
		logic [TILE_W-1:0] half;
		logic [TILE_W-1:0] lo;
		logic [63:0]       jump;
		logic [31:0]       span;
		int                kind;
		case ($urandom_range(0, 9))
			0: f.total_tiles = '0;
			1: f.total_tiles = '1;
			2, 3, 4, 5: f.total_tiles = TILE_W'($urandom_range(0, 600));
			default: f.total_tiles = TILE_W'($urandom);
		endcase
		thr = f.total_tiles >> 3;
		if (thr < MIN_THR) begin
			thr = MIN_THR;
		end
		half = f.total_tiles >> 1;
		kind = $urandom_range(0, 99);
		if (kind >= 95) begin
			f.changed_tiles = TILE_W'($urandom);
		end else if (kind < (busy ? large_pct : 10)) begin
			if (half > thr && $urandom_range(0, 99) >= over_pct) begin
				f.changed_tiles = TILE_W'($urandom_range(thr, half - 1));
			end else begin
				lo = (half > thr) ? half : thr;
				f.changed_tiles = TILE_W'($urandom_range(lo, 65535));
			end
		end else begin
			f.changed_tiles = TILE_W'($urandom_range(0, thr - 1));
		end
		case ($urandom_range(0, 7))
			0: f.target_rate = $urandom_range(0, 999999);
			1: f.target_rate = $urandom_range(1000000, 1999999);
			2: f.target_rate = ($urandom_range(0, 1) ? RATE_LOW : RATE_MID) - $urandom_range(0, 1);
			3: f.target_rate = $urandom_range(0, 1) ? '1 : '0;
			default: f.target_rate = $urandom;
		endcase
		span = cur_delay >> 2;
		if (span == '0) begin
			span = 1;
		end
		kind = $urandom_range(0, 99);
		if (kind < 3) begin
			sim_ms = sim_ms - $urandom_range(0, span);
		end else if (kind < 4) begin
			jump   = {$urandom, $urandom};
			sim_ms = jump[TIME_W-1:0];
		end else if (kind < 7) begin
			sim_ms = sim_ms + cur_delay;
		end else begin
			sim_ms = sim_ms + $urandom_range(0, span);
		end
		f.now_ms = sim_ms;
		return f;
	endfunction

	initial begin
		logic        en;
		logic [1:0]  base;
		logic [31:0] dly;
		logic [3:0]  entry;
		int          n;
		int          episode_left;
		bit          busy;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: streak of two, base step 1, 1200 ms delay
		directed_frame(16'd0, 16'd0, 32'd5000000, 48'd0);
		directed_frame(16'd31, 16'd0, 32'd5000000, 48'd10);
		directed_frame(16'd32, 16'd0, 32'd5000000, 48'd20);
		directed_frame(16'd40, 16'd0, 32'd0, 48'd30);
		directed_frame(16'd40, 16'd0, 32'd999999, 48'd40);
		directed_frame(16'd40, 16'd0, 32'd1000000, 48'd50);
		directed_frame(16'd40, 16'd0, 32'd1999999, 48'd60);
		directed_frame(16'd40, 16'd0, 32'd2000000, 48'd70);
		directed_frame(16'd40, 16'd0, 32'hFFFF_FFFF, 48'd80);
		directed_frame(16'd0, 16'd0, 32'd0, 48'd500);
		directed_frame(16'd0, 16'd0, 32'd0, 48'd5);
		directed_frame(16'd0, 16'd0, 32'd0, 48'd1279);
		directed_frame(16'd0, 16'd0, 32'd0, 48'd1280);
		directed_frame(16'd32, 16'd64, 32'd3000000, 48'd2000);
		directed_frame(16'hFFFF, 16'hFFFF, 32'd3000000, 48'hFFFF_FFFF_FFFF);
		directed_frame(16'd8191, 16'hFFFF, 32'd3000000, 48'hFFFF_FFFF_FFFF);
		directed_frame(16'd8190, 16'hFFFF, 32'd3000000, 48'hFFFF_FFFF_FFFF);
		drain();
		set_config(1'b0, 2'd2, 32'd7, 4'd3);
		directed_frame(16'hFFFF, 16'hFFFF, 32'd0, 48'd0);
		directed_frame(16'd0, 16'd0, 32'd0, 48'hFFFF_FFFF_FFFF);
		drain();
		set_config(1'b1, 2'd3, 32'd0, 4'd0);
		directed_frame(16'd0, 16'd0, 32'd0, 48'd0);
		directed_frame(16'd32766, 16'hFFFF, 32'd1500000, 48'd100);
		directed_frame(16'd32767, 16'hFFFF, 32'd1500000, 48'd110);
		drain();

		sim_ms = 48'd1000;
		for (int p = 0; p < 10; p++) begin
			en        = 1'b1;
			base      = 2'($urandom_range(0, 3));
			dly       = $urandom_range(1, 500);
			entry     = 4'($urandom_range(0, 15));
			n         = 135;
			large_pct = 70;
			over_pct  = 25;
			case (p)
				0: begin
					base = 2'd1; dly = 32'd1; entry = 4'd0;
					tx_idle_pct = 20; rx_idle_pct = 20;
				end
				1: begin
					base = 2'd2; dly = 32'd40; entry = 4'd2;
					tx_idle_pct = 0; rx_idle_pct = 0;
				end
				2: begin
					base = 2'd3; dly = 32'd200; entry = 4'd5;
					tx_idle_pct = 30; rx_idle_pct = 30;
				end
				3: begin
					// long non-overwhelming runs to drive the streak into saturation
					base = 2'd0; dly = 32'd0; entry = 4'd15;
					large_pct = 94; over_pct = 0;
					tx_idle_pct = 15; rx_idle_pct = 40;
				end
				4: begin
					base = 2'd3; dly = 32'hFFFF_FFFF; entry = 4'd1;
					tx_idle_pct = 10; rx_idle_pct = 10;
				end
				5: begin
					en = 1'b0; n = 40;
					tx_idle_pct = 25; rx_idle_pct = 25;
				end
				9: begin
					tx_idle_pct = 0; rx_idle_pct = 0;
				end
				default: begin
					tx_idle_pct = $urandom_range(0, 40);
					rx_idle_pct = $urandom_range(0, 40);
				end
			endcase
			set_config(en, base, dly, entry);
			if (p == 2) begin
				hold_rx = 1'b1;
			end
			busy = 1'b0;
			episode_left = 0;
			for (int i = 0; i < n; i++) begin
				if (episode_left == 0) begin
					busy = !busy;
					episode_left = busy ? $urandom_range(1, 40) : $urandom_range(1, 14);
				end
				episode_left--;
				send_frame(make_frame(busy));
				// back to back while the receiver holds off so the pipe fills
				if (!hold_rx) begin
					maybe_gap();
				end
			end
			drain();
		end

		$display("covered %0d frames over %0d register writes with stalls on both sides",
			sb.frames, cfg_writes);
		$display("checked %0d results, %0d of them leaving the coarse mode",
			sb.checked, sb.restores);
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", sb.pending());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
sv/mqsc_pkg.sv
sv/mqsc_decide.sv
sv/motion_quality_step_controller.sv
test/mqsc_tb_pkg.sv
test/tb.sv
